// File: hdl/ctp_pkg.sv
// Shared types, character codes and the hex digit decoder of the capability text parser.
package ctp_pkg;

	localparam int PORT_BYTES = 6;
	localparam int OBJ_BITS   = 24;
	localparam int ACC_W      = 8 * PORT_BYTES;
	localparam int PORT_W     = 48;
	localparam int NUM_OUT_W  = 24;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_S_D1   = 4'd1,
		PH_S_D2   = 4'd2,
		PH_S_SEP  = 4'd3,
		PH_SLASH1 = 4'd4,
		PH_NUM    = 4'd5,
		PH_R1     = 4'd6,
		PH_R2     = 4'd7,
		PH_RCLOSE = 4'd8,
		PH_SLASH2 = 4'd9,
		PH_C_D1   = 4'd10,
		PH_C_D2   = 4'd11,
		PH_C_SEP  = 4'd12
	} phase_t;

	typedef struct packed {
		logic       first;
		logic [7:0] ch;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [PORT_W-1:0]    server_port;
		logic [NUM_OUT_W-1:0] object_number;
		logic [7:0]           rights;
		logic [PORT_W-1:0]    check_port;
		logic                 char_used;
	} out_item_t;

	// Bit 4 flags a hex digit, bits 3:0 carry its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// File: hdl/ctp_stream_if.sv
// Valid/ready channels carrying characters in and parse results out.
interface ctp_char_if;
	logic                valid;
	logic                ready;
	ctp_pkg::in_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ctp_result_if;
	logic                valid;
	logic                ready;
	ctp_pkg::out_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/capability_text_parser.sv
// Parses capability text of the form port/number(rights)/check, one character per transaction
// on chars, and gives one transaction on results when the string completes or at its first
// syntax error. A character with first set restarts the parse; characters after a result are
// ignored until then. A character is held in the input register until the state update takes
// it and writes the result register, from which the result is offered on results. One
// character is accepted every cycle while no finished result waits on results: the phase
// and accumulator registers take one character in each update.
// While a finished result waits on results, the character in the input register is held, so
// the input stalls until that result is taken.
module capability_text_parser (
	input  logic                clk,
	input  logic                arst_n,
	ctp_char_if.sink            chars,
	ctp_result_if.source        results
);
	import ctp_pkg::*;

	logic                valid_s1;
	in_item_t            item_s1;
	logic                advance;

	phase_t              phase_q, ph;
	logic [2:0]          bidx_q, bidx;
	logic [ACC_W-1:0]    sacc_q, sacc, cacc_q, cacc;
	logic [OBJ_BITS-1:0] nacc_q, nacc;
	logic                novf_q, novf;
	logic [7:0]          racc_q, racc;

	logic                out_valid_q;
	out_item_t           out_q;

	logic [4:0]          hex;
	logic                last;
	logic [OBJ_BITS+3:0] num_next;
	logic                res_valid;
	logic                res_err;
	logic                res_used;
	out_item_t           res;

	assign advance      = valid_s1 && (!out_valid_q || results.ready);
	assign chars.ready  = !valid_s1 || advance;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1 <= chars.data;
		end
	end

	always_comb begin
		hex      = hex_decode(item_s1.ch);
		ph       = phase_q;
		bidx     = bidx_q;
		sacc     = sacc_q;
		cacc     = cacc_q;
		nacc     = nacc_q;
		novf     = novf_q;
		racc     = racc_q;
		res_valid = 1'b0;
		res_err  = 1'b0;
		res_used = 1'b0;
		num_next = '0;

		if (item_s1.first) begin
			ph   = PH_S_D1;
			bidx = '0;
			sacc = '0;
			cacc = '0;
			nacc = '0;
			novf = 1'b0;
			racc = '0;
		end
		last = ({1'b0, bidx} + 4'd1) >= 4'(PORT_BYTES);

		if (item_s1.first || phase_q != PH_IDLE) begin
			case (ph)
				PH_S_D1: begin
					if (!hex[4]) begin
						res_err = 1'b1;
					end else begin
						sacc = (sacc << 8) | ACC_W'(hex[3:0]);
						ph   = PH_S_D2;
					end
				end
				PH_S_D2: begin
					if (hex[4]) begin
						sacc[7:0] = {sacc[3:0], hex[3:0]};
						if (last) begin
							bidx = '0;
							ph   = PH_SLASH1;
						end else begin
							bidx = bidx + 3'd1;
							ph   = PH_S_SEP;
						end
					end else if (last) begin
						// A one-digit byte: the closing character must be the separator.
						if (item_s1.ch == CH_SLASH) begin
							bidx = '0;
							ph   = PH_NUM;
						end else begin
							res_err = 1'b1;
						end
					end else if (item_s1.ch == CH_COLON) begin
						bidx = bidx + 3'd1;
						ph   = PH_S_D1;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_S_SEP: begin
					if (item_s1.ch == CH_COLON) begin
						ph = PH_S_D1;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_SLASH1: begin
					if (item_s1.ch == CH_SLASH) begin
						ph = PH_NUM;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_NUM: begin
					if (item_s1.ch >= CH_ZERO && item_s1.ch <= CH_NINE) begin
						num_next = ((OBJ_BITS+4)'(nacc) << 3) + ((OBJ_BITS+4)'(nacc) << 1)
							+ (OBJ_BITS+4)'(item_s1.ch[3:0]);
						if (num_next[OBJ_BITS+3:OBJ_BITS] != 4'd0) begin
							novf = 1'b1;
						end
						nacc = num_next[OBJ_BITS-1:0];
					end else if (item_s1.ch == CH_OPEN) begin
						ph = PH_R1;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_R1: begin
					if (!hex[4]) begin
						res_err = 1'b1;
					end else begin
						racc = {4'd0, hex[3:0]};
						ph   = PH_R2;
					end
				end
				PH_R2: begin
					if (hex[4]) begin
						racc = {racc[3:0], hex[3:0]};
						ph   = PH_RCLOSE;
					end else if (item_s1.ch == CH_CLOSE) begin
						ph = PH_SLASH2;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_RCLOSE: begin
					if (item_s1.ch == CH_CLOSE) begin
						ph = PH_SLASH2;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_SLASH2: begin
					if (item_s1.ch == CH_SLASH) begin
						bidx = '0;
						ph   = PH_C_D1;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_C_D1: begin
					if (!hex[4]) begin
						res_err = 1'b1;
					end else begin
						cacc = (cacc << 8) | ACC_W'(hex[3:0]);
						ph   = PH_C_D2;
					end
				end
				PH_C_D2: begin
					if (hex[4]) begin
						cacc[7:0] = {cacc[3:0], hex[3:0]};
						if (last) begin
							res_valid = 1'b1;
							res_used  = 1'b1;
						end else begin
							bidx = bidx + 3'd1;
							ph   = PH_C_SEP;
						end
					end else if (last) begin
						// The ending character belongs to whatever follows the text.
						res_valid = 1'b1;
					end else if (item_s1.ch == CH_COLON) begin
						bidx = bidx + 3'd1;
						ph   = PH_C_D1;
					end else begin
						res_err = 1'b1;
					end
				end
				PH_C_SEP: begin
					if (item_s1.ch == CH_COLON) begin
						ph = PH_C_D1;
					end else begin
						res_err = 1'b1;
					end
				end
				default: begin
					ph = PH_IDLE;
				end
			endcase
		end

		if (res_err) begin
			res_valid = 1'b1;
		end
		if (res_valid) begin
			ph = PH_IDLE;
		end

		res = '0;
		if (res_err) begin
			res.status = ST_SYNTAX;
		end else begin
			res.status        = novf ? ST_RANGE : ST_OK;
			res.server_port   = PORT_W'(sacc);
			res.object_number = novf ? '0 : NUM_OUT_W'(nacc);
			res.rights        = racc;
			res.check_port    = PORT_W'(cacc);
			res.char_used     = res_used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bidx_q      <= '0;
			sacc_q      <= '0;
			cacc_q      <= '0;
			nacc_q      <= '0;
			novf_q      <= 1'b0;
			racc_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= ph;
				bidx_q  <= bidx;
				sacc_q  <= sacc;
				cacc_q  <= cacc;
				nacc_q  <= nacc;
				novf_q  <= novf;
				racc_q  <= racc;
			end
			out_valid_q <= (out_valid_q && !results.ready) || (advance && res_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

endmodule
